### hw/rtl/phx_pkg.sv
`default_nettype none
package phx_pkg;

  localparam int unsigned ROUNDS = 10;

  localparam int unsigned ADDR_W = 6;
  localparam int unsigned DATA_W = 64;

  localparam logic [31:0] MUL_A  = 32'hd2511f53;
  localparam logic [31:0] MUL_B  = 32'hcd9e8d57;
  localparam logic [31:0] WEYL_A = 32'h9e3779b9;
  localparam logic [31:0] WEYL_B = 32'hbb67ae85;

  // blocks per row: ceil(columns / 4) needs 31 bits at most
  localparam int unsigned BLK_W = 31;

  typedef enum logic [2:0] {
    REG_BASE_LOW  = 3'd0,
    REG_BASE_HIGH = 3'd1,
    REG_KEY_LOW   = 3'd2,
    REG_KEY_HIGH  = 3'd3,
    REG_COLUMNS   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [63:0]      base_low;
    logic [63:0]      base_high;
    logic [31:0]      key_low;
    logic [31:0]      key_high;
    logic [BLK_W-1:0] blocks;
  } cfg_t;

  // one pipeline slot: counter words in flight plus the round key
  typedef struct packed {
    logic [3:0][31:0] w;
    logic [31:0]      k0;
    logic [31:0]      k1;
  } slot_t;

endpackage
`default_nettype wire

### hw/rtl/phx_regs.sv
`default_nettype none
module phx_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [phx_pkg::ADDR_W-1:0] paddr,
  input  wire logic [phx_pkg::DATA_W-1:0] pwdata,
  output logic      [phx_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output phx_pkg::cfg_t                   cfg_o
);

  logic [63:0] base_low_q;
  logic [63:0] base_high_q;
  logic [31:0] key_low_q;
  logic [31:0] key_high_q;
  logic [31:0] columns_q;
  logic [phx_pkg::BLK_W-1:0] blocks_q, blocks_d;
  logic [2:0]  idx;
  logic        wr_en;

  assign idx    = paddr[phx_pkg::ADDR_W-1:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // ceiling of the new column count over four, kept ready for the index stage
  assign blocks_d = phx_pkg::BLK_W'((33'(pwdata[31:0]) + 33'd3) >> 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_low_q  <= '0;
      base_high_q <= '0;
      key_low_q   <= '0;
      key_high_q  <= '0;
      columns_q   <= 32'd1;
      blocks_q    <= phx_pkg::BLK_W'(1);
    end else if (wr_en) begin
      case (idx)
        phx_pkg::REG_BASE_LOW:  base_low_q  <= pwdata;
        phx_pkg::REG_BASE_HIGH: base_high_q <= pwdata;
        phx_pkg::REG_KEY_LOW:   key_low_q   <= pwdata[31:0];
        phx_pkg::REG_KEY_HIGH:  key_high_q  <= pwdata[31:0];
        phx_pkg::REG_COLUMNS: begin
          columns_q <= pwdata[31:0];
          blocks_q  <= blocks_d;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      phx_pkg::REG_BASE_LOW:  prdata = base_low_q;
      phx_pkg::REG_BASE_HIGH: prdata = base_high_q;
      phx_pkg::REG_KEY_LOW:   prdata = 64'(key_low_q);
      phx_pkg::REG_KEY_HIGH:  prdata = 64'(key_high_q);
      phx_pkg::REG_COLUMNS:   prdata = 64'(columns_q);
      default:                prdata = '0;
    endcase
  end

  assign cfg_o.base_low  = base_low_q;
  assign cfg_o.base_high = base_high_q;
  assign cfg_o.key_low   = key_low_q;
  assign cfg_o.key_high  = key_high_q;
  assign cfg_o.blocks    = blocks_q;

  a_blocks_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blocks_q == phx_pkg::BLK_W'((33'(columns_q) + 33'd3) >> 2))
    else $error("blocks per row out of step with column count");

endmodule
`default_nettype wire

### hw/rtl/phx_index.sv
`default_nettype none
module phx_index (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [31:0]   row_i,
  input  wire logic [31:0]   col_i,
  input  wire phx_pkg::cfg_t cfg_i,
  output logic               valid_o,
  output phx_pkg::slot_t     slot_o
);

  logic [3:0]  v_q;
  logic [62:0] prod_q;
  logic [29:0] colq_q;
  logic [63:0] idx_q;
  logic [63:0] lo_q;
  logic        carry_q;
  logic [64:0] lo_sum;
  logic [63:0] hi;
  phx_pkg::slot_t slot_q;

  assign lo_sum = 65'(cfg_i.base_low) + 65'(idx_q);
  assign hi     = cfg_i.base_high + 64'(carry_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q    <= 63'(row_i) * 63'(cfg_i.blocks);
      colq_q    <= col_i[31:2];
      idx_q     <= 64'(prod_q) + 64'(colq_q);
      lo_q      <= lo_sum[63:0];
      carry_q   <= lo_sum[64];
      slot_q.w  <= {hi, lo_q};
      slot_q.k0 <= cfg_i.key_low;
      slot_q.k1 <= cfg_i.key_high;
    end
  end

  assign valid_o = v_q[3];
  assign slot_o  = slot_q;

endmodule
`default_nettype wire

### hw/rtl/phx_round.sv
`default_nettype none
module phx_round (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire phx_pkg::slot_t slot_i,
  output logic                valid_o,
  output phx_pkg::slot_t      slot_o
);

  logic [63:0]    p0;
  logic [63:0]    p1;
  logic           valid_q;
  phx_pkg::slot_t slot_q;

  assign p0 = 64'(phx_pkg::MUL_A) * 64'(slot_i.w[0]);
  assign p1 = 64'(phx_pkg::MUL_B) * 64'(slot_i.w[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      slot_q.w[0] <= p1[63:32] ^ slot_i.w[1] ^ slot_i.k0;
      slot_q.w[1] <= p1[31:0];
      slot_q.w[2] <= p0[63:32] ^ slot_i.w[3] ^ slot_i.k1;
      slot_q.w[3] <= p0[31:0];
      slot_q.k0   <= slot_i.k0 + phx_pkg::WEYL_A;
      slot_q.k1   <= slot_i.k1 + phx_pkg::WEYL_B;
    end
  end

  assign valid_o = valid_q;
  assign slot_o  = slot_q;

endmodule
`default_nettype wire

### hw/rtl/philox_counter_random_block_core.sv
`default_nettype none
// Philox4x32-10 random block generator. Each request (row, start column) yields
// four 32-bit words for counter base + row * ceil(columns / 4) + start column / 4
// under the configured 64-bit key. Fully pipelined: one request is taken every
// cycle while no result is held back, and passes through four counter-forming
// stages and one stage per Philox round, each holding its two 32x32 multiplies. A
// stalled result freezes the whole pipeline, so in_stall_o follows out_stall_i
// only while a result is waiting. Registers sit on an APB port at 8-byte steps:
// base low, base high, key low, key high, columns per row; change them only
// while no request is in flight.
module philox_counter_random_block_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [phx_pkg::ADDR_W-1:0] paddr,
  input  wire logic [phx_pkg::DATA_W-1:0] pwdata,
  output logic      [phx_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [31:0]                row_number_i,
  input  wire logic [31:0]                start_col_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic      [31:0]                word_0_o,
  output logic      [31:0]                word_1_o,
  output logic      [31:0]                word_2_o,
  output logic      [31:0]                word_3_o
);

  phx_pkg::cfg_t  cfg;
  logic           adv;
  logic [phx_pkg::ROUNDS:0] vld;
  phx_pkg::slot_t slot [phx_pkg::ROUNDS+1];

  phx_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // pipeline moves unless a finished result is held back
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  phx_index u_index (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .row_i   (row_number_i),
    .col_i   (start_col_i),
    .cfg_i   (cfg),
    .valid_o (vld[0]),
    .slot_o  (slot[0])
  );

  for (genvar r = 0; r < phx_pkg::ROUNDS; r++) begin : g_round
    phx_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (vld[r]),
      .slot_i  (slot[r]),
      .valid_o (vld[r+1]),
      .slot_o  (slot[r+1])
    );
  end

  assign out_valid_o = vld[phx_pkg::ROUNDS];
  assign word_0_o    = slot[phx_pkg::ROUNDS].w[0];
  assign word_1_o    = slot[phx_pkg::ROUNDS].w[1];
  assign word_2_o    = slot[phx_pkg::ROUNDS].w[2];
  assign word_3_o    = slot[phx_pkg::ROUNDS].w[3];

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld))
    else $error("round stages moved while pipeline frozen");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !vld[phx_pkg::ROUNDS-1]) |=> !out_valid_o)
    else $error("result appeared from an empty round stage");

endmodule
`default_nettype wire
